@@ rtl/core/pwmc_pkg.sv @@
// ----------------------------------------------------------------------------
// pwmc_pkg: shared types and constants of the pwm period and duty calculator
// Holds the transaction codes, the sequencer states and the arithmetic
// constants used by the calculator and its shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package pwmc_pkg;

   // default sizing of the timer block
   localparam int NumTimerUnits      = 4;
   localparam int FirstTimerChannels = 8;
   localparam int OtherTimerChannels = 2;

   // slot addressing: slot = timer * 8 + channel
   localparam int ChanPerTimer = 8;
   localparam int SlotCount    = 32;
   localparam int SlotWidth    = $clog2(SlotCount);

   // field widths
   localparam int ClockWidth   = 28;
   localparam int DutyWidth    = 31;
   localparam int ModuloWidth  = 16;
   localparam int CompareWidth = 17;
   localparam int CsrIdxWidth  = 4;

   // arithmetic constants
   localparam int unsigned SlowClockHz = 31250;
   localparam int unsigned ModLimit    = 65536;
   localparam int unsigned DutyFull    = 32767;
   localparam int          DutyShift   = 16;
   localparam int          ClockShift  = 7;
   localparam int          SlowShift   = ClockShift + $clog2(ModLimit);

   // shared divider sizing
   localparam int DividendWidth = 32;
   localparam int DivisorWidth  = ClockWidth;
   localparam int DivCountWidth = $clog2(DividendWidth);

   typedef enum logic [1:0] {
      OP_SET_FREQ    = 2'd0,
      OP_SET_DUTY    = 2'd1,
      OP_RELEASE     = 2'd2,
      OP_RELEASE_ALL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_SETUP   = 2'd0,
      KIND_COMPARE = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_MAIN = 2'd1,
      SRC_SLOW = 2'd2
   } src_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CLOCK_HZ = 4'd0,
      CSR_SLOW_OK  = 4'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_PERIOD,
      ST_NORMALIZE,
      ST_SCAN,
      ST_SCALE,
      ST_DIV_CMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      kind_type                 kind;
      logic [1:0]               out_timer;
      logic [2:0]               out_channel;
      src_type                  clock_source;
      logic [3:0]               prescale;
      logic [ModuloWidth-1:0]   modulo;
      logic                     out_center;
      logic [CompareWidth-1:0]  compare_value;
      logic                     last;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/pwmc_if.sv @@
// ----------------------------------------------------------------------------
// pwmc channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwmc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [1:0]  timer;
   logic [2:0]  channel;
   logic [27:0] frequency_hz;
   logic        center_aligned;
   logic [30:0] duty_value;

   modport source (output valid, operation, timer, channel, frequency_hz,
                   center_aligned, duty_value, input ready);
   modport sink   (input valid, operation, timer, channel, frequency_hz,
                   center_aligned, duty_value, output ready);
endinterface

interface pwmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  out_timer;
   logic [2:0]  out_channel;
   logic [1:0]  clock_source;
   logic [3:0]  prescale;
   logic [15:0] modulo;
   logic        out_center;
   logic [16:0] compare_value;
   logic        last;

   modport source (output valid, kind, out_timer, out_channel, clock_source,
                   prescale, modulo, out_center, compare_value, last,
                   input ready);
   modport sink   (input valid, kind, out_timer, out_channel, clock_source,
                   prescale, modulo, out_center, compare_value, last,
                   output ready);
endinterface

interface pwmc_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [27:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pwm_period_duty_calculator_top.sv @@
// ----------------------------------------------------------------------------
// pwm_period_duty_calculator_top: pwm timer period and duty calculator
// Works out prescale, modulo and channel compare values for the pwm timers.
// ----------------------------------------------------------------------------
// The block takes one request transaction at a time and is not ready until
// the last response of that request has been taken. A frequency request runs
// one division on the shared divider, then normalizes the quotient one bit
// per cycle (up to 12 shifts, then a store step) before the setup response.
// Every active channel of that timer then follows with one compare response,
// each costing a scan step per slot passed, a duty read, one multiply and
// another division (a duty with zero in bits 30:16 skips the division).
// A duty request costs one multiply and one division (none when it skips the
// division), a release no division, and a release-all one scan step per slot
// passed and one response per active channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_period_duty_calculator_top #(
   parameter int NUM_TIMER_UNITS      = pwmc_pkg::NumTimerUnits,
   parameter int FIRST_TIMER_CHANNELS = pwmc_pkg::FirstTimerChannels,
   parameter int OTHER_TIMER_CHANNELS = pwmc_pkg::OtherTimerChannels
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pwmc_req_if.sink   req_bus,
   pwmc_rsp_if.source rsp_bus,
   pwmc_csr_if.sink   csr_bus
);

   localparam int SW = pwmc_pkg::SlotWidth;
   localparam int MW = pwmc_pkg::ModuloWidth;
   localparam int CW = pwmc_pkg::CompareWidth;
   localparam int DW = pwmc_pkg::DividendWidth;
   localparam int KW = pwmc_pkg::ClockWidth;

   // configuration registers
   logic [KW-1:0] clk_hz_ff;
   logic          slow_ok_ff;

   // sequencer and captured request
   pwmc_pkg::state_type state_ff, state_in;
   pwmc_pkg::op_type    op_ff, op_in;
   logic [1:0]          tm_ff, tm_in;
   logic [2:0]          ch_ff, ch_in;
   logic                ctr_ff, ctr_in;
   logic [30:0]         duty_ff, duty_in;
   pwmc_pkg::src_type   src_ff, src_in;
   logic [3:0]          ps_ff, ps_in;
   logic [DW-1:0]       quo_ff, quo_in;
   logic [SW-1:0]       scan_ff, scan_in;
   pwmc_pkg::rsp_type   rsp_ff, rsp_in;

   // timer and channel state
   logic [MW-1:0]                    period_ff [4];
   logic [MW-1:0]                    period_in [4];
   logic [pwmc_pkg::SlotCount-1:0]   act_ff, act_in;

   // duty store: only read for active channels, so it needs no reset
   logic [30:0] duty_mem [pwmc_pkg::SlotCount];
   logic [30:0] duty_rd_ff;
   logic        mem_we;

   // shared divider hookup
   logic          div_start;
   logic [DW-1:0] div_dividend;
   logic [KW-1:0] div_divisor;
   logic          div_done;
   logic [DW-1:0] div_quotient;

   // request decode
   logic                req_fire, rsp_fire;
   pwmc_pkg::op_type    op_req;
   logic                tm_ok, ch_ok;
   logic                slow_sel;
   logic [KW-1:0]       clk_sel;
   logic [DW-1:0]       period_dvd;

   // compare path
   logic [30:0]   duty_src;
   logic [14:0]   duty_hi;
   logic [16:0]   mod_plus;
   logic [DW-1:0] scale_prod;
   logic [7:0]    tm_blk;
   logic          higher_tm, higher_all;
   logic [2:0]    cmp_ch;
   logic          cmp_last;
   logic [MW-1:0] mo_val;

   function automatic pwmc_pkg::rsp_type make_rsp(
      input pwmc_pkg::kind_type kind,
      input logic [1:0]         tm,
      input logic [2:0]         ch,
      input pwmc_pkg::src_type  src,
      input logic [3:0]         ps,
      input logic [MW-1:0]      mo,
      input logic               ctr,
      input logic [CW-1:0]      cmp,
      input logic               last
   );
      pwmc_pkg::rsp_type r;
      r.kind          = kind;
      r.out_timer     = tm;
      r.out_channel   = ch;
      r.clock_source  = src;
      r.prescale      = ps;
      r.modulo        = mo;
      r.out_center    = ctr;
      r.compare_value = cmp;
      r.last          = last;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------
   assign req_bus.ready = (state_ff == pwmc_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = (state_ff == pwmc_pkg::ST_EMIT);
   assign rsp_fire      = rsp_bus.valid && rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.kind          = rsp_ff.kind;
   assign rsp_bus.out_timer     = rsp_ff.out_timer;
   assign rsp_bus.out_channel   = rsp_ff.out_channel;
   assign rsp_bus.clock_source  = rsp_ff.clock_source;
   assign rsp_bus.prescale      = rsp_ff.prescale;
   assign rsp_bus.modulo        = rsp_ff.modulo;
   assign rsp_bus.out_center    = rsp_ff.out_center;
   assign rsp_bus.compare_value = rsp_ff.compare_value;
   assign rsp_bus.last          = rsp_ff.last;

   // ------------------------------------------------------------------
   // register writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff  <= KW'(48000000);
         slow_ok_ff <= 1'b1;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            pwmc_pkg::CSR_CLOCK_HZ: clk_hz_ff  <= csr_bus.data;
            pwmc_pkg::CSR_SLOW_OK:  slow_ok_ff <= csr_bus.data[0];
            default: ;  // unknown register, write dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // request decode
   // ------------------------------------------------------------------
   assign op_req = pwmc_pkg::op_type'(req_bus.operation);
   assign tm_ok  = int'(req_bus.timer) < NUM_TIMER_UNITS;
   assign ch_ok  = tm_ok && (int'(req_bus.channel) <
                   ((req_bus.timer == 2'd0) ? FIRST_TIMER_CHANNELS : OTHER_TIMER_CHANNELS));

   // slow clock, if allowed, when frequency < (clock >> 7) / 65536
   assign slow_sel   = slow_ok_ff &&
                       (req_bus.frequency_hz < KW'(clk_hz_ff >> pwmc_pkg::SlowShift));
   assign clk_sel    = slow_sel ? KW'(pwmc_pkg::SlowClockHz) : clk_hz_ff;
   // rounded clock / frequency
   assign period_dvd = DW'(clk_sel) + DW'(req_bus.frequency_hz >> 1);

   // ------------------------------------------------------------------
   // compare value: (duty >> 16) * (modulo + 1) / 32767
   // ------------------------------------------------------------------
   assign duty_src   = (op_ff == pwmc_pkg::OP_SET_FREQ) ? duty_rd_ff : duty_ff;
   assign duty_hi    = duty_src[30:pwmc_pkg::DutyShift];
   assign mod_plus   = {1'b0, period_ff[tm_ff]} + 17'd1;
   assign scale_prod = {17'b0, duty_hi} * {15'b0, mod_plus};

   // is there another active channel after the scan position
   assign tm_blk     = act_ff[{tm_ff, 3'b000} +: pwmc_pkg::ChanPerTimer];
   assign higher_tm  = |(8'(tm_blk >> scan_ff[2:0]) >> 1);
   assign higher_all = |((act_ff >> scan_ff) >> 1);

   // frequency requests report the scanned channel, duty requests their own
   assign cmp_ch   = (op_ff == pwmc_pkg::OP_SET_FREQ) ? scan_ff[2:0] : ch_ff;
   assign cmp_last = (op_ff == pwmc_pkg::OP_SET_FREQ) ? !higher_tm : 1'b1;

   // a rounded result of zero is forced to one, giving modulo zero
   assign mo_val = (quo_ff == '0) ? '0 : MW'(quo_ff - 1'b1);

   assign div_dividend = (state_ff == pwmc_pkg::ST_IDLE) ? period_dvd : scale_prod;
   assign div_divisor  = (state_ff == pwmc_pkg::ST_IDLE) ? req_bus.frequency_hz
                                                         : KW'(pwmc_pkg::DutyFull);

   pwmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      tm_in     = tm_ff;
      ch_in     = ch_ff;
      ctr_in    = ctr_ff;
      duty_in   = duty_ff;
      src_in    = src_ff;
      ps_in     = ps_ff;
      quo_in    = quo_ff;
      scan_in   = scan_ff;
      rsp_in    = rsp_ff;
      period_in = period_ff;
      act_in    = act_ff;
      div_start = 1'b0;
      mem_we    = 1'b0;

      unique case (state_ff)
         pwmc_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in   = op_req;
               tm_in   = req_bus.timer;
               ch_in   = req_bus.channel;
               ctr_in  = req_bus.center_aligned;
               duty_in = req_bus.duty_value;
               src_in  = slow_sel ? pwmc_pkg::SRC_SLOW : pwmc_pkg::SRC_MAIN;
               ps_in   = '0;
               rsp_in  = make_rsp(pwmc_pkg::KIND_ERROR, req_bus.timer, req_bus.channel,
                                  pwmc_pkg::SRC_NONE, '0, '0, 1'b0, '0, 1'b1);
               unique case (op_req)
                  pwmc_pkg::OP_SET_FREQ: begin
                     scan_in = {req_bus.timer, 3'b000};
                     if (!tm_ok || req_bus.frequency_hz == '0) begin
                        state_in = pwmc_pkg::ST_EMIT;
                     end else begin
                        div_start = 1'b1;
                        state_in  = pwmc_pkg::ST_DIV_PERIOD;
                     end
                  end
                  pwmc_pkg::OP_SET_DUTY: begin
                     if (!ch_ok) begin
                        state_in = pwmc_pkg::ST_EMIT;
                     end else begin
                        mem_we = 1'b1;
                        act_in[{req_bus.timer, req_bus.channel}] = 1'b1;
                        state_in = pwmc_pkg::ST_SCALE;
                     end
                  end
                  pwmc_pkg::OP_RELEASE: begin
                     if (ch_ok) begin
                        act_in[{req_bus.timer, req_bus.channel}] = 1'b0;
                        rsp_in = make_rsp(pwmc_pkg::KIND_COMPARE, req_bus.timer,
                                          req_bus.channel, pwmc_pkg::SRC_NONE,
                                          '0, '0, 1'b0, '0, 1'b1);
                     end
                     state_in = pwmc_pkg::ST_EMIT;
                  end
                  pwmc_pkg::OP_RELEASE_ALL: begin
                     scan_in = '0;
                     // nothing active: no response at all
                     state_in = (act_ff == '0) ? pwmc_pkg::ST_IDLE : pwmc_pkg::ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end

         pwmc_pkg::ST_DIV_PERIOD: begin
            if (div_done) begin
               quo_in   = div_quotient;
               state_in = pwmc_pkg::ST_NORMALIZE;
            end
         end

         pwmc_pkg::ST_NORMALIZE: begin
            // halve until the count fits the 16-bit counter
            if (quo_ff > DW'(pwmc_pkg::ModLimit)) begin
               quo_in = quo_ff >> 1;
               ps_in  = ps_ff + 4'd1;
            end else begin
               period_in[tm_ff] = mo_val;
               rsp_in = make_rsp(pwmc_pkg::KIND_SETUP, tm_ff, 3'd0, src_ff, ps_ff,
                                 mo_val, ctr_ff, '0, ~|tm_blk);
               state_in = pwmc_pkg::ST_EMIT;
            end
         end

         pwmc_pkg::ST_SCAN: begin
            if (act_ff[scan_ff]) begin
               if (op_ff == pwmc_pkg::OP_RELEASE_ALL) begin
                  act_in[scan_ff] = 1'b0;
                  rsp_in = make_rsp(pwmc_pkg::KIND_COMPARE, scan_ff[4:3], scan_ff[2:0],
                                    pwmc_pkg::SRC_NONE, '0, '0, 1'b0, '0, !higher_all);
                  state_in = pwmc_pkg::ST_EMIT;
               end else begin
                  // duty read lands in duty_rd_ff on this edge
                  state_in = pwmc_pkg::ST_SCALE;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         pwmc_pkg::ST_SCALE: begin
            if (duty_hi == '0) begin
               rsp_in = make_rsp(pwmc_pkg::KIND_COMPARE, tm_ff, cmp_ch, pwmc_pkg::SRC_NONE,
                                 '0, '0, 1'b0, '0, cmp_last);
               state_in = pwmc_pkg::ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = pwmc_pkg::ST_DIV_CMP;
            end
         end

         pwmc_pkg::ST_DIV_CMP: begin
            if (div_done) begin
               rsp_in = make_rsp(pwmc_pkg::KIND_COMPARE, tm_ff, cmp_ch, pwmc_pkg::SRC_NONE,
                                 '0, '0, 1'b0, CW'(div_quotient), cmp_last);
               state_in = pwmc_pkg::ST_EMIT;
            end
         end

         pwmc_pkg::ST_EMIT: begin
            if (rsp_fire) begin
               if (rsp_ff.last) begin
                  state_in = pwmc_pkg::ST_IDLE;
               end else if (rsp_ff.kind == pwmc_pkg::KIND_SETUP) begin
                  state_in = pwmc_pkg::ST_SCAN;
               end else begin
                  scan_in  = scan_ff + 1'b1;
                  state_in = pwmc_pkg::ST_SCAN;
               end
            end
         end

         default: state_in = pwmc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pwmc_pkg::ST_IDLE;
         act_ff    <= '0;
         period_ff <= '{default: '0};
      end else begin
         state_ff  <= state_in;
         act_ff    <= act_in;
         period_ff <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      tm_ff   <= tm_in;
      ch_ff   <= ch_in;
      ctr_ff  <= ctr_in;
      duty_ff <= duty_in;
      src_ff  <= src_in;
      ps_ff   <= ps_in;
      quo_ff  <= quo_in;
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
   end

   // duty store, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         duty_mem[{req_bus.timer, req_bus.channel}] <= req_bus.duty_value;
      end
      duty_rd_ff <= duty_mem[scan_ff];
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------

   // a pending response always blocks new requests
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("request accepted while a response is pending");

   // every normalize step bumps the prescale by one
   a_prescale_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pwmc_pkg::ST_NORMALIZE && quo_ff > DW'(pwmc_pkg::ModLimit))
      |=> ps_ff == $past(ps_ff) + 4'd1)
      else $error("prescale did not advance with the shift");

   // a setup response reports the modulo that was stored for its timer
   a_setup_modulo: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_ff.kind == pwmc_pkg::KIND_SETUP)
      |-> rsp_ff.modulo == period_ff[rsp_ff.out_timer])
      else $error("setup modulo differs from stored modulo");

   // scanning only happens while some channel is still active
   a_scan_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == pwmc_pkg::ST_SCAN |-> act_ff != '0)
      else $error("slot scan with no active channel");

   // divider results only arrive while the sequencer waits for them
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == pwmc_pkg::ST_DIV_PERIOD ||
                    state_ff == pwmc_pkg::ST_DIV_CMP))
      else $error("divider finished outside a divide state");

endmodule

`default_nettype wire

@@ rtl/core/pwmc_div.sv @@
// ----------------------------------------------------------------------------
// pwmc_div: shared restoring divider
// Unsigned divide, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmc_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [pwmc_pkg::DividendWidth-1:0]  dividend,
   input  wire logic [pwmc_pkg::DivisorWidth-1:0]   divisor,
   output logic                                     done,
   output logic [pwmc_pkg::DividendWidth-1:0]       quotient
);

   localparam int DW = pwmc_pkg::DividendWidth;
   localparam int VW = pwmc_pkg::DivisorWidth;
   localparam int CW = pwmc_pkg::DivCountWidth;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [DW-1:0] qd_ff, qd_in;

   logic [VW:0]   rem_shift;
   logic          fits;
   logic [VW:0]   rem_sub;

   // partial remainder shifted by one dividend bit
   assign rem_shift = {rem_ff, qd_ff[DW-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};
   assign rem_sub   = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      qd_in   = qd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         qd_in   = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[VW-1:0] : rem_shift[VW-1:0];
         qd_in  = {qd_ff[DW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      qd_ff  <= qd_in;
   end

   assign done     = done_ff;
   assign quotient = qd_ff;

endmodule

`default_nettype wire
